@@ rtl/asa_pkg.sv @@
// ----------------------------------------------------------------------------
// asa_pkg
// shared constants, codes and controller/datapath command and status types
// ----------------------------------------------------------------------------
package asa_pkg;

  // store geometry
  localparam int MAX_WEIGHTS      = 128;
  localparam int MAX_OBJECTIVES   = 8;
  localparam int SLOTS_PER_REGION = 32;

  // field widths
  localparam int KIND_W = 2;
  localparam int REG_W  = 7;
  localparam int COMP_W = 3;
  localparam int VAL_W  = 32;
  localparam int ID_W   = 8;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;
  localparam int SLOT_W = 5;
  localparam int WT_W   = 16;

  // arithmetic widths
  localparam int PROD_W = 48;   // objective times weight
  localparam int D_W    = 51;   // signed dot product accumulator
  localparam int AD_W   = 50;   // magnitude of dot product
  localparam int N_W    = 35;   // squared weight norm
  localparam int SQ_W   = 100;  // squared dot product
  localparam int PR_W   = 135;  // squared dot product times norm
  localparam int MB_W   = 50;   // multiplier operand b

  // configuration
  localparam int NW_W       = 8;
  localparam int NOBJ_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECTIVES = 2'd1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OBJ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_STORED    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // result selection
  localparam int RES_W = 3;
  localparam logic [RES_W-1:0] RES_WEIGHT    = 3'd0;
  localparam logic [RES_W-1:0] RES_OBJ       = 3'd1;
  localparam logic [RES_W-1:0] RES_CLEAR     = 3'd2;
  localparam logic [RES_W-1:0] RES_APPEND    = 3'd3;
  localparam logic [RES_W-1:0] RES_NOT_FOUND = 3'd4;
  localparam logic [RES_W-1:0] RES_DELETE    = 3'd5;

  typedef struct packed {
    logic             cap;
    logic             wt_wr;
    logic             vb_wr;
    logic             cnt_clr;
    logic             acc_clr;
    logic             wt_rd;
    logic             acc_en;
    logic             met_first;
    logic             mul1;
    logic             mul2;
    logic             best_upd;
    logic             cnt_rd;
    logic             cnt_rd_best;
    logic             c_load;
    logic             lst_rd;
    logic             lst_rd_sh;
    logic             lst_wr_sh;
    logic             res_en;
    logic [RES_W-1:0] res_sel;
    logic             out_load;
    logic             reg_clr;
    logic             reg_inc;
    logic             k_inc;
    logic             slot_clr;
    logic             slot_inc;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              last;
    logic              k_end;
    logic              reg_end;
    logic              reg_zero;
    logic              reg_last;
    logic              mul_busy;
    logic              slot_end;
    logic              sh_end;
    logic              match;
    logic              out_free;
  } stat_t;

endpackage

@@ rtl/asa_if.sv @@
// ----------------------------------------------------------------------------
// asa_in_if / asa_out_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface asa_in_if;
  import asa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [REG_W-1:0]         region_index;
  logic [COMP_W-1:0]        component_index;
  logic signed [VAL_W-1:0]  value;
  logic [ID_W-1:0]          member_id;
  logic                     last_component;

  modport source (output valid, kind, region_index, component_index, value, member_id,
                  last_component, input ready);
  modport sink   (input valid, kind, region_index, component_index, value, member_id,
                  last_component, output ready);
endinterface

interface asa_out_if;
  import asa_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [REG_W-1:0]  region;
  logic [CNT_W-1:0]  member_count;
  logic [ID_W-1:0]   echo_id;

  modport source (output valid, status, region, member_count, echo_id, input ready);
  modport sink   (input valid, status, region, member_count, echo_id, output ready);
endinterface

@@ rtl/asa_mul.sv @@
// ----------------------------------------------------------------------------
// asa_mul
// shift-add multiplier, one bit of b per cycle, stops early once b runs out
// ----------------------------------------------------------------------------
module asa_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [asa_pkg::PR_W-1:0]  a,
  input  logic [asa_pkg::MB_W-1:0]  b,
  output logic                      busy,
  output logic [asa_pkg::PR_W-1:0]  p
);
  import asa_pkg::*;

  logic            busy_r;
  logic [PR_W-1:0] a_r;
  logic [MB_W-1:0] b_r;
  logic [PR_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (b_r == '0)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[PR_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[MB_W-1:1]};
    end
  end

  assign busy = busy_r;
  assign p    = acc_r;

endmodule

@@ rtl/asa_dp.sv @@
// ----------------------------------------------------------------------------
// asa_dp
// datapath: stores, dot product accumulator, cross-multiply compare, counters
// ----------------------------------------------------------------------------
module asa_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  asa_pkg::cmd_t                  cmd,
  output asa_pkg::stat_t                 st,
  input  logic                           cfg_we,
  input  logic [asa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [asa_pkg::KIND_W-1:0]     in_kind,
  input  logic [asa_pkg::REG_W-1:0]      in_region_index,
  input  logic [asa_pkg::COMP_W-1:0]     in_component_index,
  input  logic signed [asa_pkg::VAL_W-1:0] in_value,
  input  logic [asa_pkg::ID_W-1:0]       in_member_id,
  input  logic                           in_last_component,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [asa_pkg::STAT_W-1:0]     out_status,
  output logic [asa_pkg::REG_W-1:0]      out_region,
  output logic [asa_pkg::CNT_W-1:0]      out_member_count,
  output logic [asa_pkg::ID_W-1:0]       out_echo_id
);
  import asa_pkg::*;

  localparam int WT_DEPTH  = MAX_WEIGHTS * MAX_OBJECTIVES;
  localparam int LST_DEPTH = MAX_WEIGHTS * SLOTS_PER_REGION;

  // configuration
  logic [NW_W-1:0]   nw_cfg_r;
  logic [NOBJ_W-1:0] nobj_cfg_r;
  logic [NW_W-1:0]   nw;
  logic [NOBJ_W-1:0] nobj;

  // captured item
  logic [KIND_W-1:0]       kind_r;
  logic [REG_W-1:0]        regidx_r;
  logic [COMP_W-1:0]       comp_r;
  logic signed [VAL_W-1:0] val_r;
  logic [ID_W-1:0]         id_r;
  logic                    last_r;

  // stores
  logic [WT_W-1:0]         wt_mem [WT_DEPTH];
  logic [WT_W-1:0]         wt_q_r;
  logic signed [VAL_W-1:0] vbuf_r [MAX_OBJECTIVES];
  logic [CNT_W-1:0]        cnt_mem [MAX_WEIGHTS];
  logic                    cnt_vld_r [MAX_WEIGHTS];
  logic [CNT_W-1:0]        cnt_q_r;
  logic                    cnt_qv_r;
  logic [ID_W-1:0]         lst_mem [LST_DEPTH];
  logic [ID_W-1:0]         lst_q_r;

  // counters
  logic [NW_W-1:0]   reg_cnt_r;
  logic [NOBJ_W-1:0] k_r;
  logic [CNT_W-1:0]  slot_r;
  logic [CNT_W-1:0]  c_r;

  // metrics
  logic signed [D_W-1:0]    d_r;
  logic [N_W-1:0]           n_r;
  logic signed [PROD_W-1:0] prod;
  logic [2*WT_W-1:0]        wsq;
  logic signed [D_W-1:0]    dneg;
  logic [AD_W-1:0]          ad;
  logic [AD_W-1:0]          bd_r;
  logic [N_W-1:0]           bn_r;
  logic [REG_W-1:0]         best_r;

  // multipliers
  logic            mul_start;
  logic [PR_W-1:0] ml_a, mr_a, ml_p, mr_p;
  logic [MB_W-1:0] ml_b, mr_b;
  logic            ml_busy, mr_busy;
  logic            gt;

  // count and list access
  logic [CNT_W-1:0] cnt_val;
  logic             full;
  logic             app_wr;
  logic             dec_wr;
  logic             cnt_wr;
  logic [REG_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic [REG_W-1:0] cnt_raddr;
  logic [CNT_W-1:0] slot_p1;
  logic [REG_W+SLOT_W-1:0] lst_raddr;

  // result
  logic [STAT_W-1:0] res_status_r;
  logic [REG_W-1:0]  res_region_r;
  logic [CNT_W-1:0]  res_count_r;
  logic [ID_W-1:0]   res_id_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [REG_W-1:0]  out_region_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [ID_W-1:0]   out_id_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nw_cfg_r   <= NW_W'(1);
      nobj_cfg_r <= NOBJ_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WEIGHTS:    nw_cfg_r   <= cfg_wdata[NW_W-1:0];
        CFG_OBJECTIVES: nobj_cfg_r <= cfg_wdata[NOBJ_W-1:0];
        default: ;
      endcase
    end
  end

  assign nw = (nw_cfg_r == '0) ? NW_W'(1) :
              (nw_cfg_r > NW_W'(MAX_WEIGHTS)) ? NW_W'(MAX_WEIGHTS) : nw_cfg_r;
  assign nobj = (nobj_cfg_r > NOBJ_W'(MAX_OBJECTIVES)) ? NOBJ_W'(MAX_OBJECTIVES) : nobj_cfg_r;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r   <= in_kind;
      regidx_r <= in_region_index;
      comp_r   <= in_component_index;
      val_r    <= in_value;
      id_r     <= in_member_id;
      last_r   <= in_last_component;
    end
  end

  // weight table
  always_ff @(posedge clk) begin
    if (cmd.wt_wr) begin
      wt_mem[{regidx_r, comp_r}] <= val_r[WT_W-1:0];
    end
    if (cmd.wt_rd) begin
      wt_q_r <= wt_mem[{reg_cnt_r[REG_W-1:0], k_r[COMP_W-1:0]}];
    end
  end

  // objective vector
  always_ff @(posedge clk) begin
    if (cmd.vb_wr) begin
      vbuf_r[comp_r] <= val_r;
    end
  end

  // dot product and norm, one component a step
  assign prod = vbuf_r[k_r[COMP_W-1:0]] * $signed({1'b0, wt_q_r});
  assign wsq  = {{WT_W{1'b0}}, wt_q_r} * {{WT_W{1'b0}}, wt_q_r};
  assign dneg = -d_r;
  assign ad   = d_r[D_W-1] ? dneg[AD_W-1:0] : d_r[AD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      d_r <= '0;
      n_r <= '0;
    end else if (cmd.acc_en) begin
      d_r <= d_r + D_W'(prod);
      n_r <= n_r + N_W'(wsq);
    end
  end

  // cross-multiplied compare: |d_j|^2 * n_best against |d_best|^2 * n_j
  assign mul_start = cmd.mul1 | cmd.mul2;
  assign ml_a = cmd.mul2 ? PR_W'(ml_p[SQ_W-1:0]) : PR_W'(ad);
  assign ml_b = cmd.mul2 ? MB_W'(bn_r) : ad;
  assign mr_a = cmd.mul2 ? PR_W'(mr_p[SQ_W-1:0]) : PR_W'(bd_r);
  assign mr_b = cmd.mul2 ? MB_W'(n_r) : bd_r;

  asa_mul u_mul_l (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (ml_a),
    .b     (ml_b),
    .busy  (ml_busy),
    .p     (ml_p)
  );

  asa_mul u_mul_r (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mr_a),
    .b     (mr_b),
    .busy  (mr_busy),
    .p     (mr_p)
  );

  assign gt = ml_p > mr_p;

  always_ff @(posedge clk) begin
    if (cmd.met_first) begin
      bd_r   <= ad;
      bn_r   <= n_r;
      best_r <= '0;
    end else if (cmd.best_upd && gt) begin
      bd_r   <= ad;
      bn_r   <= n_r;
      best_r <= reg_cnt_r[REG_W-1:0];
    end
  end

  // member counts
  assign cnt_val   = cnt_qv_r ? cnt_q_r : '0;
  assign full      = cnt_val >= CNT_W'(SLOTS_PER_REGION);
  assign app_wr    = cmd.res_en && (cmd.res_sel == RES_APPEND) && !full;
  assign dec_wr    = cmd.res_en && (cmd.res_sel == RES_DELETE);
  assign cnt_wr    = app_wr | dec_wr;
  assign cnt_waddr = app_wr ? best_r : reg_cnt_r[REG_W-1:0];
  assign cnt_wdata = app_wr ? cnt_val + CNT_W'(1) : c_r - CNT_W'(1);
  assign cnt_raddr = cmd.cnt_rd_best ? best_r : reg_cnt_r[REG_W-1:0];

  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cmd.cnt_rd) begin
      cnt_q_r  <= cnt_mem[cnt_raddr];
      cnt_qv_r <= cnt_vld_r[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      for (int i = 0; i < MAX_WEIGHTS; i++) begin
        cnt_vld_r[i] <= 1'b0;
      end
    end else if (cnt_wr) begin
      cnt_vld_r[cnt_waddr] <= 1'b1;
    end
  end

  // member lists
  assign slot_p1   = slot_r + CNT_W'(1);
  assign lst_raddr = cmd.lst_rd_sh ? {reg_cnt_r[REG_W-1:0], slot_p1[SLOT_W-1:0]}
                                   : {reg_cnt_r[REG_W-1:0], slot_r[SLOT_W-1:0]};

  always_ff @(posedge clk) begin
    if (app_wr) begin
      lst_mem[{best_r, cnt_val[SLOT_W-1:0]}] <= id_r;
    end else if (cmd.lst_wr_sh) begin
      lst_mem[{reg_cnt_r[REG_W-1:0], slot_r[SLOT_W-1:0]}] <= lst_q_r;
    end
    if (cmd.lst_rd || cmd.lst_rd_sh) begin
      lst_q_r <= lst_mem[lst_raddr];
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (cmd.reg_clr) begin
      reg_cnt_r <= '0;
    end else if (cmd.reg_inc) begin
      reg_cnt_r <= reg_cnt_r + NW_W'(1);
    end
    if (cmd.acc_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + NOBJ_W'(1);
    end
    if (cmd.slot_clr) begin
      slot_r <= '0;
    end else if (cmd.slot_inc) begin
      slot_r <= slot_p1;
    end
    if (cmd.c_load) begin
      c_r <= cnt_val;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      res_status_r <= ST_DONE;
      res_region_r <= '0;
      res_count_r  <= '0;
      res_id_r     <= '0;
      case (cmd.res_sel)
        RES_WEIGHT: begin
          res_status_r <= ST_STORED;
          res_region_r <= regidx_r;
        end
        RES_OBJ: res_status_r <= ST_STORED;
        RES_APPEND: begin
          res_status_r <= full ? ST_FULL : ST_DONE;
          res_region_r <= best_r;
          res_count_r  <= full ? cnt_val : cnt_val + CNT_W'(1);
          res_id_r     <= id_r;
        end
        RES_NOT_FOUND: begin
          res_status_r <= ST_NOT_FOUND;
          res_id_r     <= id_r;
        end
        RES_DELETE: begin
          res_region_r <= reg_cnt_r[REG_W-1:0];
          res_count_r  <= c_r - CNT_W'(1);
          res_id_r     <= id_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_region_r <= res_region_r;
      out_count_r  <= res_count_r;
      out_id_r     <= res_id_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region       = out_region_r;
  assign out_member_count = out_count_r;
  assign out_echo_id      = out_id_r;

  // status to controller
  assign st.kind     = kind_r;
  assign st.last     = last_r;
  assign st.k_end    = k_r == nobj;
  assign st.reg_end  = reg_cnt_r == nw;
  assign st.reg_zero = reg_cnt_r == '0;
  assign st.reg_last = ({1'b0, reg_cnt_r} + (NW_W+1)'(1)) == {1'b0, nw};
  assign st.mul_busy = ml_busy | mr_busy;
  assign st.slot_end = slot_r == c_r;
  assign st.sh_end   = slot_p1 >= c_r;
  assign st.match    = lst_q_r == id_r;
  assign st.out_free = !out_valid_r || out_ready;

endmodule

@@ rtl/asa_ctrl.sv @@
// ----------------------------------------------------------------------------
// asa_ctrl
// sequencer for weight and objective loads, classification, delete and clear
// ----------------------------------------------------------------------------
module asa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  asa_pkg::stat_t  st,
  output asa_pkg::cmd_t   cmd
);
  import asa_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] S_DEC      = 5'd1;
  localparam logic [ST_W-1:0] S_CL_START = 5'd2;
  localparam logic [ST_W-1:0] S_CL_RD    = 5'd3;
  localparam logic [ST_W-1:0] S_CL_ACC   = 5'd4;
  localparam logic [ST_W-1:0] S_CL_MET   = 5'd5;
  localparam logic [ST_W-1:0] S_CL_SQ    = 5'd6;
  localparam logic [ST_W-1:0] S_CL_PR    = 5'd7;
  localparam logic [ST_W-1:0] S_CL_NEXT  = 5'd8;
  localparam logic [ST_W-1:0] S_CL_APP   = 5'd9;
  localparam logic [ST_W-1:0] S_DL_CRD   = 5'd10;
  localparam logic [ST_W-1:0] S_DL_CNT   = 5'd11;
  localparam logic [ST_W-1:0] S_DL_RD    = 5'd12;
  localparam logic [ST_W-1:0] S_DL_CMP   = 5'd13;
  localparam logic [ST_W-1:0] S_DL_SH    = 5'd14;
  localparam logic [ST_W-1:0] S_DL_SHW   = 5'd15;
  localparam logic [ST_W-1:0] S_FIN      = 5'd16;

  logic [ST_W-1:0] state_r;
  logic [ST_W-1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (st.kind)
          KIND_WEIGHT: begin
            cmd.wt_wr   = 1'b1;
            cmd.res_en  = 1'b1;
            cmd.res_sel = RES_WEIGHT;
            state_nxt   = S_FIN;
          end
          KIND_OBJ: begin
            cmd.vb_wr = 1'b1;
            if (!st.last) begin
              cmd.res_en  = 1'b1;
              cmd.res_sel = RES_OBJ;
              state_nxt   = S_FIN;
            end else begin
              cmd.reg_clr = 1'b1;
              state_nxt   = S_CL_START;
            end
          end
          KIND_DELETE: begin
            cmd.reg_clr = 1'b1;
            state_nxt   = S_DL_CRD;
          end
          KIND_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.res_en  = 1'b1;
            cmd.res_sel = RES_CLEAR;
            state_nxt   = S_FIN;
          end
          default: ;
        endcase
      end
      S_CL_START: begin
        cmd.acc_clr = 1'b1;
        state_nxt   = S_CL_RD;
      end
      S_CL_RD: begin
        if (st.k_end) begin
          state_nxt = S_CL_MET;
        end else begin
          cmd.wt_rd = 1'b1;
          state_nxt = S_CL_ACC;
        end
      end
      S_CL_ACC: begin
        cmd.acc_en = 1'b1;
        cmd.k_inc  = 1'b1;
        state_nxt  = S_CL_RD;
      end
      S_CL_MET: begin
        if (st.reg_zero) begin
          cmd.met_first = 1'b1;
          state_nxt     = S_CL_NEXT;
        end else begin
          cmd.mul1  = 1'b1;
          state_nxt = S_CL_SQ;
        end
      end
      S_CL_SQ: begin
        if (!st.mul_busy) begin
          cmd.mul2  = 1'b1;
          state_nxt = S_CL_PR;
        end
      end
      S_CL_PR: begin
        if (!st.mul_busy) begin
          cmd.best_upd = 1'b1;
          state_nxt    = S_CL_NEXT;
        end
      end
      S_CL_NEXT: begin
        if (st.reg_last) begin
          cmd.cnt_rd      = 1'b1;
          cmd.cnt_rd_best = 1'b1;
          state_nxt       = S_CL_APP;
        end else begin
          cmd.reg_inc = 1'b1;
          state_nxt   = S_CL_START;
        end
      end
      S_CL_APP: begin
        cmd.res_en  = 1'b1;
        cmd.res_sel = RES_APPEND;
        state_nxt   = S_FIN;
      end
      S_DL_CRD: begin
        if (st.reg_end) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_NOT_FOUND;
          state_nxt   = S_FIN;
        end else begin
          cmd.cnt_rd = 1'b1;
          state_nxt  = S_DL_CNT;
        end
      end
      S_DL_CNT: begin
        cmd.c_load   = 1'b1;
        cmd.slot_clr = 1'b1;
        state_nxt    = S_DL_RD;
      end
      S_DL_RD: begin
        if (st.slot_end) begin
          cmd.reg_inc = 1'b1;
          state_nxt   = S_DL_CRD;
        end else begin
          cmd.lst_rd = 1'b1;
          state_nxt  = S_DL_CMP;
        end
      end
      S_DL_CMP: begin
        if (st.match) begin
          state_nxt = S_DL_SH;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_DL_RD;
        end
      end
      S_DL_SH: begin
        if (st.sh_end) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_DELETE;
          state_nxt   = S_FIN;
        end else begin
          cmd.lst_rd_sh = 1'b1;
          state_nxt     = S_DL_SHW;
        end
      end
      S_DL_SHW: begin
        cmd.lst_wr_sh = 1'b1;
        cmd.slot_inc  = 1'b1;
        state_nxt     = S_DL_SH;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/angle_subregion_association_core.sv @@
// ----------------------------------------------------------------------------
// angle_subregion_association_core
// angle-based subregion association store with per-subregion member lists
// ----------------------------------------------------------------------------
// sequence: classification walks every weight in use, accumulating each objective
//   component, and for each weight after the first waits on the two bit-serial
//   multipliers of the cross-multiplied compare; delete searches subregion by
//   subregion, compares each member and shifts up every member after a hit
// throughput: one item at a time, the next is taken once the result is in
//   the output register, even while that result still waits
// reset: synchronous active-low, counts read as zero, weights_in_use = 1,
//   objectives_in_use = 2; weight table and lists hold garbage until written
module angle_subregion_association_core (
  input  logic                           clk,
  input  logic                           rst_n,
  asa_in_if.sink                         in_ch,
  asa_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [asa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import asa_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t st;
  logic  in_ready;

  // sequencer: decodes the item kind, walks weights for classification,
  // walks lists for delete, and hands the result to the output register
  asa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // datapath: weight table, objective buffer, count and list memories,
  // dot product accumulator and the pair of multipliers for the compare
  asa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_kind            (in_ch.kind),
    .in_region_index    (in_ch.region_index),
    .in_component_index (in_ch.component_index),
    .in_value           (in_ch.value),
    .in_member_id       (in_ch.member_id),
    .in_last_component  (in_ch.last_component),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_region         (out_ch.region),
    .out_member_count   (out_ch.member_count),
    .out_echo_id        (out_ch.echo_id)
  );

endmodule
